// ===== rtl/quadrature_decoder_accel_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Quadrature decoder assertion macros
// Shared property forms for the checker; clk and rst_n come from the scope.
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_DECODER_ACCEL_UNIT_ASSERT_SVH
`define QUADRATURE_DECODER_ACCEL_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define QDEC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qdec assertion failed");

// Check a consequent in the cycle after its antecedent
`define QDEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qdec assertion failed");

`endif

// ===== rtl/qdec_pkg.sv =====
// ---------------------------------------------------------------------------
// Quadrature decoder package
// Types, register map, reset values and the phase transition table.
// ---------------------------------------------------------------------------
package qdec_pkg;

    // Field widths
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned STEP_W   = 8;
    localparam int unsigned SUB_W    = 4;
    localparam int unsigned SUM_W    = POS_W + 2;

    // APB port
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CLAMP  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_PAUSE_US  = 2'd0,
        REG_FAST_STEP = 2'd1,
        REG_POS_MIN   = 2'd2,
        REG_POS_MAX   = 2'd3
    } reg_idx_t;

    // Reset values
    localparam logic [TIME_W-1:0] PAUSE_US_RST  = 32'd50000;
    localparam logic [STEP_W-1:0] FAST_STEP_RST = 8'd10;
    localparam logic [POS_W-1:0]  POS_MIN_RST   = 16'h8000;
    localparam logic [POS_W-1:0]  POS_MAX_RST   = 16'h7fff;
    localparam logic [1:0]        PHASES_RST    = 2'b11;

    // Sub-count at which a detent is taken
    localparam logic [SUB_W-1:0] SUB_UP   = 4'b0100;
    localparam logic [SUB_W-1:0] SUB_DOWN = 4'b1100;

    // Saturation bounds
    localparam logic [POS_W-1:0] POS_HI = 16'h7fff;
    localparam logic [POS_W-1:0] POS_LO = 16'h8000;

    typedef struct packed {
        logic [TIME_W-1:0] pause_us;
        logic [STEP_W-1:0] fast_step;
        logic [POS_W-1:0]  pos_min;
        logic [POS_W-1:0]  pos_max;
    } qdec_cfg_t;

    typedef struct packed {
        logic [1:0]        prev_phases;
        logic [SUB_W-1:0]  sub_count;
        logic [TIME_W-1:0] last_up_time;
        logic [TIME_W-1:0] last_down_time;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  reported;
    } qdec_state_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             moved;
    } qdec_result_t;

    // Step for a {previous, current} phase pair: 2'b01 = +1, 2'b11 = -1
    function automatic logic [1:0] step_lut(input logic [3:0] idx);
        logic [1:0] step;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  step = 2'b11;
            4'd2, 4'd4, 4'd11, 4'd13: step = 2'b01;
            default:                  step = 2'b00;
        endcase
        return step;
    endfunction

endpackage

// ===== rtl/qdec_if.sv =====
// ---------------------------------------------------------------------------
// Quadrature decoder stream interfaces
// Valid/ready channels for input items and for results.
// ---------------------------------------------------------------------------
interface qdec_in_if;
    import qdec_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic                    phase_a;
    logic                    phase_b;
    logic [TIME_W-1:0]       now_us;
    logic signed [POS_W-1:0] load_value;

    modport source (output valid, opcode, phase_a, phase_b, now_us, load_value,
                    input ready);
    modport sink (input valid, opcode, phase_a, phase_b, now_us, load_value,
                  output ready);
endinterface

interface qdec_out_if;
    import qdec_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic                    moved;

    modport source (output valid, position, moved, input ready);
    modport sink (input valid, position, moved, output ready);
endinterface

// ===== rtl/qdec_regs.sv =====
// ---------------------------------------------------------------------------
// Quadrature decoder configuration registers
// APB write and read of pause window, fast step and clamp limits.
// ---------------------------------------------------------------------------
module qdec_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qdec_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [qdec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [qdec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output qdec_pkg::qdec_cfg_t                cfg
);
    import qdec_pkg::*;

    qdec_cfg_t cfg_reg;
    qdec_cfg_t cfg_next;
    reg_idx_t  sel_idx;
    logic      wr_en;

    assign sel_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Merge the write data into the selected register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel_idx)
                REG_PAUSE_US:  cfg_next.pause_us  = pwdata[TIME_W-1:0];
                REG_FAST_STEP: cfg_next.fast_step = pwdata[STEP_W-1:0];
                REG_POS_MIN:   cfg_next.pos_min   = pwdata[POS_W-1:0];
                REG_POS_MAX:   cfg_next.pos_max   = pwdata[POS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pause_us  <= PAUSE_US_RST;
            cfg_reg.fast_step <= FAST_STEP_RST;
            cfg_reg.pos_min   <= POS_MIN_RST;
            cfg_reg.pos_max   <= POS_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back; limits sign-extend to the bus
    always_comb
    begin
        case (sel_idx)
            REG_PAUSE_US:  prdata = cfg_reg.pause_us;
            REG_FAST_STEP: prdata = {{(APB_DATA_W-STEP_W){1'b0}}, cfg_reg.fast_step};
            REG_POS_MIN:   prdata = {{(APB_DATA_W-POS_W){cfg_reg.pos_min[POS_W-1]}},
                                     cfg_reg.pos_min};
            REG_POS_MAX:   prdata = {{(APB_DATA_W-POS_W){cfg_reg.pos_max[POS_W-1]}},
                                     cfg_reg.pos_max};
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/qdec_core.sv =====
// ---------------------------------------------------------------------------
// Quadrature decoder datapath
// Next state and result for one item: table step, detent move with
// acceleration and saturation, load and clamp.
// ---------------------------------------------------------------------------
module qdec_core (
    input  qdec_pkg::qdec_state_t                 cur,
    input  qdec_pkg::qdec_cfg_t                   cfg,
    input  logic [qdec_pkg::OPCODE_W-1:0]         opcode,
    input  logic                                  phase_a,
    input  logic                                  phase_b,
    input  logic [qdec_pkg::TIME_W-1:0]           now_us,
    input  logic [qdec_pkg::POS_W-1:0]            load_value,
    output qdec_pkg::qdec_state_t                 nxt,
    output qdec_pkg::qdec_result_t                res
);
    import qdec_pkg::*;

    op_t               op;
    logic [1:0]        step;
    logic [SUB_W-1:0]  sub_sum;
    logic              go_up;
    logic              go_down;
    logic [TIME_W-1:0] dt;
    logic              fast;
    logic [STEP_W-1:0] mag;
    logic [SUM_W-1:0]  delta;
    logic [SUM_W-1:0]  pos_sum;
    logic [POS_W-1:0]  pos_move;
    logic [POS_W-1:0]  pos_lo;
    logic [POS_W-1:0]  pos_clamp;

    assign op = op_t'(opcode);

    // Table step into the sub-count
    assign step    = step_lut({cur.prev_phases, phase_a, phase_b});
    assign sub_sum = cur.sub_count + {{(SUB_W-2){step[1]}}, step};
    assign go_up   = (sub_sum == SUB_UP);
    assign go_down = (sub_sum == SUB_DOWN);

    // Acceleration: wrapping time since the last move in this direction
    assign dt   = now_us - (go_down ? cur.last_down_time : cur.last_up_time);
    assign fast = (dt < cfg.pause_us);
    assign mag  = fast ? cfg.fast_step : STEP_W'(1);

    // Signed move and saturation to 16 bits
    always_comb
    begin
        if (go_up)
            delta = {{(SUM_W-STEP_W){1'b0}}, mag};
        else if (go_down)
            delta = -{{(SUM_W-STEP_W){1'b0}}, mag};
        else
            delta = '0;
        pos_sum = {{(SUM_W-POS_W){cur.position[POS_W-1]}}, cur.position} + delta;
        if ($signed(pos_sum) > $signed({{(SUM_W-POS_W){1'b0}}, POS_HI}))
            pos_move = POS_HI;
        else if ($signed(pos_sum) < $signed({{(SUM_W-POS_W){1'b1}}, POS_LO}))
            pos_move = POS_LO;
        else
            pos_move = pos_sum[POS_W-1:0];
    end

    // Clamp: raise to the minimum, then lower to the maximum
    assign pos_lo    = ($signed(cur.position) < $signed(cfg.pos_min)) ? cfg.pos_min
                                                                      : cur.position;
    assign pos_clamp = ($signed(pos_lo) > $signed(cfg.pos_max)) ? cfg.pos_max : pos_lo;

    // Select by operation
    always_comb
    begin
        nxt       = cur;
        res.moved = 1'b0;
        case (op)
            OP_SAMPLE:
            begin
                nxt.prev_phases = {phase_a, phase_b};
                nxt.sub_count   = (go_up || go_down) ? '0 : sub_sum;
                if (go_up)
                    nxt.last_up_time = now_us;
                if (go_down)
                    nxt.last_down_time = now_us;
                nxt.position = pos_move;
                nxt.reported = pos_move;
                res.moved    = (pos_move != cur.reported);
            end
            OP_LOAD:  nxt.position = load_value;
            OP_CLAMP: nxt.position = pos_clamp;
            default:  nxt = cur;
        endcase
        res.position = nxt.position;
    end

endmodule

// ===== rtl/quadrature_decoder_accel_unit.sv =====
// An item's result is registered in the output slot, else in the skid slot.
// Throughput: one item per cycle while the skid slot is empty; the decode and
// move logic sits between the state registers and the result register.
// A two-entry result buffer keeps input open while one result waits.
// Reset: rst_n clears state and config to their defaults at once,
// no clearing pass; items can be accepted as soon as reset is released.
// ---------------------------------------------------------------------------
// Quadrature decoder with acceleration
// Top level: item handshake, decoder state, result and skid registers.
// ---------------------------------------------------------------------------
module quadrature_decoder_accel_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    qdec_in_if.sink                         in_ch,
    qdec_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qdec_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qdec_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qdec_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import qdec_pkg::*;

    qdec_cfg_t    cfg;
    qdec_state_t  state_reg;
    qdec_state_t  state_next;
    qdec_result_t new_res;
    qdec_result_t out_reg;
    qdec_result_t out_next;
    qdec_result_t skid_reg;
    qdec_result_t skid_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    logic         in_fire;
    logic         out_fire;

    qdec_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qdec_core u_core (
        .cur        (state_reg),
        .cfg        (cfg),
        .opcode     (in_ch.opcode),
        .phase_a    (in_ch.phase_a),
        .phase_b    (in_ch.phase_b),
        .now_us     (in_ch.now_us),
        .load_value (in_ch.load_value),
        .nxt        (state_next),
        .res        (new_res)
    );

    // Handshake
    assign in_ch.ready = !skid_valid_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_valid_reg && out_ch.ready;

    // Advance decoder state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_phases    <= PHASES_RST;
            state_reg.sub_count      <= '0;
            state_reg.last_up_time   <= '0;
            state_reg.last_down_time <= '0;
            state_reg.position       <= '0;
            state_reg.reported       <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result and skid slots: older result always in the output slot
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_next       = new_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_next       = new_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.position = out_reg.position;
    assign out_ch.moved    = out_reg.moved;

endmodule

// ===== rtl/qdec_checker.sv =====
// ---------------------------------------------------------------------------
// Quadrature decoder port checker
// Watches the top level's ports; attached by bind.
// ---------------------------------------------------------------------------
`include "quadrature_decoder_accel_unit_assert.svh"

module qdec_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [qdec_pkg::OPCODE_W-1:0]   in_opcode,
    input logic [qdec_pkg::POS_W-1:0]      in_load_value,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [qdec_pkg::POS_W-1:0]      out_position,
    input logic                            pready
);
    import qdec_pkg::*;

    // Result stays offered until taken
    `QDEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // Input closes only while a result is waiting
    `QDEC_ASSERT_SAME(a_stall_cause, !in_ready, out_valid)

    // A load into an empty output shows up as the next result
    `QDEC_ASSERT_NEXT(a_load_pass, in_valid && in_ready && !out_valid && (in_opcode == OP_LOAD), out_valid && (out_position == $past(in_load_value)))

    // Register port never inserts wait states
    `QDEC_ASSERT_SAME(a_no_wait, 1'b1, pready)

endmodule

bind quadrature_decoder_accel_unit qdec_checker u_qdec_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_opcode     (in_ch.opcode),
    .in_load_value (in_ch.load_value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_position  (out_ch.position),
    .pready        (pready)
);

// ===== tb/quadrature_decoder_accel_unit_check.sv =====
// ---------------------------------------------------------------------------
// Quadrature decoder result checker
// Watches the item, result and register ports, tracks its own copy of the
// decoder state and settings, and compares every result transfer against
// the oldest predicted position and motion flag.
// ---------------------------------------------------------------------------
module quadrature_decoder_accel_unit_check
    import qdec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    qdec_in_if                    in_ch,
    qdec_out_if                   out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    awaiting,
    output int                    reports_checked,
    output int                    motion_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    // Quarter step for each {previous pins, current pins} pair
    localparam int QUARTER_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

    // Settings as last written over the register port
    logic [TIME_W-1:0]        win_us;
    logic [STEP_W-1:0]        burst_step;
    logic signed [POS_W-1:0]  floor_pos;
    logic signed [POS_W-1:0]  ceil_pos;

    // Decoder state
    logic [1:0]               pins_prev;
    logic signed [SUB_W-1:0]  quarter_count;
    logic [TIME_W-1:0]        up_stamp;
    logic [TIME_W-1:0]        down_stamp;
    logic signed [POS_W-1:0]  cur_pos;
    logic signed [POS_W-1:0]  shown_pos;

    qdec_result_t             awaited_reports[$];
    int                       errs;
    int                       n_checked;
    int                       n_moves;

    // Advance the decoder by one item and return the report it produces
    function automatic qdec_result_t decode_item(logic [OPCODE_W-1:0] opcode, logic a, logic b,
                                                 logic [TIME_W-1:0] now,
                                                 logic signed [POS_W-1:0] load);
        qdec_result_t res;
        logic [3:0]   idx;
        int           change;
        int           sum;
        bit           detent;
        res.moved = 1'b0;
        detent = 1'b0;
        change = 0;
        case (op_t'(opcode))
            OP_SAMPLE:
            begin
                idx = {pins_prev, a, b};
                pins_prev = {a, b};
                quarter_count = quarter_count + SUB_W'(QUARTER_STEP[idx]);
                if (quarter_count > 3)
                begin
                    change = 1;
                    if (now - up_stamp < win_us)
                        change = int'(burst_step);
                    up_stamp = now;
                    detent = 1'b1;
                end
                else if (quarter_count < -3)
                begin
                    change = -1;
                    if (now - down_stamp < win_us)
                        change = -int'(burst_step);
                    down_stamp = now;
                    detent = 1'b1;
                end
                // Saturate the move to the 16-bit signed range
                if (detent)
                begin
                    sum = int'(cur_pos) + change;
                    if (sum > 32767)
                        sum = 32767;
                    else if (sum < -32768)
                        sum = -32768;
                    cur_pos = POS_W'(sum);
                    quarter_count = '0;
                end
                if (cur_pos != shown_pos)
                begin
                    shown_pos = cur_pos;
                    res.moved = 1'b1;
                end
            end
            OP_LOAD:
                cur_pos = load;
            OP_CLAMP:
            begin
                if (cur_pos < floor_pos)
                    cur_pos = floor_pos;
                if (cur_pos > ceil_pos)
                    cur_pos = ceil_pos;
            end
            default:
                ;
        endcase
        res.position = cur_pos;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        qdec_result_t want;
        if (!rst_n)
        begin
            win_us        = PAUSE_US_RST;
            burst_step    = FAST_STEP_RST;
            floor_pos     = POS_MIN_RST;
            ceil_pos      = POS_MAX_RST;
            pins_prev     = PHASES_RST;
            quarter_count = '0;
            up_stamp      = '0;
            down_stamp    = '0;
            cur_pos       = '0;
            shown_pos     = '0;
            awaited_reports.delete();
            errs      = 0;
            n_checked = 0;
            n_moves   = 0;
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_PAUSE_US:  win_us     = pwdata[TIME_W-1:0];
                    REG_FAST_STEP: burst_step = pwdata[STEP_W-1:0];
                    REG_POS_MIN:   floor_pos  = pwdata[POS_W-1:0];
                    REG_POS_MAX:   ceil_pos   = pwdata[POS_W-1:0];
                    default:       ;
                endcase
            end

            // Compare a result transfer with the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    errs++;
                    $display("%0t: result with none expected: position %0d moved %0b",
                             $time, out_ch.position, out_ch.moved);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    n_checked++;
                    if (want.moved)
                        n_moves++;
                    if (out_ch.position !== want.position)
                    begin
                        errs++;
                        $display("%0t: position mismatch: expected %0d actual %0d",
                                 $time, $signed(want.position), out_ch.position);
                    end
                    if (out_ch.moved !== want.moved)
                    begin
                        errs++;
                        $display("%0t: moved mismatch: expected %0b actual %0b",
                                 $time, want.moved, out_ch.moved);
                    end
                end
            end

            // Predict the report for an item transfer
            if (in_ch.valid && in_ch.ready)
                awaited_reports.push_back(decode_item(in_ch.opcode, in_ch.phase_a,
                                                      in_ch.phase_b, in_ch.now_us,
                                                      in_ch.load_value));
        end
        fail_count      <= errs;
        awaiting        <= awaited_reports.size();
        reports_checked <= n_checked;
        motion_reports  <= n_moves;
    end

endmodule

// ===== tb/quadrature_decoder_accel_unit_test.sv =====
// ---------------------------------------------------------------------------
// Quadrature decoder testbench
// Drives pin samples, loads and clamps into the decoder under a range of
// acceleration and limit settings, with random gaps on both channels; the
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module quadrature_decoder_accel_unit_test;
    import qdec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 60;

    // Pin levels {a, b} around one detent, in the counting-up order
    localparam logic [1:0] PHASE_RING [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    awaiting;
    int                    reports_checked;
    int                    motion_reports;
    int                    cycles = 0;

    // Stimulus state
    bit                    idle_on;
    bit                    going_up;
    int                    run_left;
    int                    hold_left;
    logic [1:0]            turn_k;
    logic [TIME_W-1:0]     clock_us;
    logic [TIME_W-1:0]     cur_pause;

    qdec_in_if  in_ch();
    qdec_out_if out_ch();

    quadrature_decoder_accel_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    quadrature_decoder_accel_unit_check pos_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .awaiting        (awaiting),
        .reports_checked (reports_checked),
        .motion_reports  (motion_reports)
    );

    always #(CLK_HALF) clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: accept, with random stall bursts while idle gaps are on
    initial
    begin
        out_ch.ready = 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Present one item and hold it until the transfer
    task automatic send_item(op_t op, logic [1:0] pins, logic [TIME_W-1:0] now,
                             logic signed [POS_W-1:0] load);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.phase_a    <= pins[1];
        in_ch.phase_b    <= pins[0];
        in_ch.now_us     <= now;
        in_ch.load_value <= load;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Turn the pins through one full detent
    task automatic turn_detent(bit up, logic [TIME_W-1:0] now);
        repeat (4)
        begin
            turn_k = up ? turn_k + 2'd1 : turn_k - 2'd1;
            send_item(OP_SAMPLE, PHASE_RING[turn_k], now, POS_W'($urandom));
        end
    endtask

    // Drop valid and hold off until every result is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Write all four registers once the block is idle
    task automatic apply_settings(logic [TIME_W-1:0] pause, logic [STEP_W-1:0] step,
                                  logic signed [POS_W-1:0] lo, logic signed [POS_W-1:0] hi);
        wait_drained();
        write_reg(REG_PAUSE_US, pause);
        write_reg(REG_FAST_STEP, APB_DATA_W'(step));
        write_reg(REG_POS_MIN, APB_DATA_W'(lo));
        write_reg(REG_POS_MAX, APB_DATA_W'(hi));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_pause = pause;
        @(posedge clk);
    endtask

    // Mostly clean rotation in runs, with glitches, loads, clamps and unused codes
    task automatic run_random(int count);
        int                      pick;
        int                      gap_sel;
        logic [1:0]              pins;
        logic signed [POS_W-1:0] load;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            gap_sel = $urandom_range(0, 9);
            if (gap_sel < 5)
                clock_us += $urandom_range(0, 200);
            else if (gap_sel < 7)
                clock_us += cur_pause - 1 + $urandom_range(0, 2);
            else if (gap_sel < 9)
                clock_us += $urandom_range(0, cur_pause);
            else
                clock_us += $urandom;
            load = POS_W'($urandom);
            case ($urandom_range(0, 7))
                0: load = 16'sh7fff;
                1: load = -16'sh8000;
                2: load = 16'sh7fff - POS_W'($urandom_range(0, 20));
                3: load = -16'sh8000 + POS_W'($urandom_range(0, 20));
                default: ;
            endcase
            if (pick < 75)
            begin
                if (run_left == 0)
                begin
                    going_up = 1'($urandom_range(0, 1));
                    run_left = $urandom_range(2, 40);
                end
                run_left--;
                turn_k = going_up ? turn_k + 2'd1 : turn_k - 2'd1;
                send_item(OP_SAMPLE, PHASE_RING[turn_k], clock_us, load);
            end
            else if (pick < 83)
            begin
                pins = 2'($urandom_range(0, 3));
                for (int j = 0; j < 4; j++)
                    if (PHASE_RING[j] == pins)
                        turn_k = 2'(j);
                send_item(OP_SAMPLE, pins, clock_us, load);
            end
            else if (pick < 90)
                send_item(OP_LOAD, 2'($urandom_range(0, 3)), $urandom, load);
            else if (pick < 96)
                send_item(OP_CLAMP, 2'($urandom_range(0, 3)), $urandom, load);
            else
                send_item(OP_NONE, 2'($urandom_range(0, 3)), $urandom, load);
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0]       pause;
        logic [STEP_W-1:0]       step;
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = '0;
        in_ch.phase_a    = 1'b1;
        in_ch.phase_b    = 1'b1;
        in_ch.now_us     = '0;
        in_ch.load_value = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        idle_on          = 1'b1;
        run_left         = 0;
        turn_k           = 2'd0;
        clock_us         = '0;
        cur_pause        = PAUSE_US_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: accelerated and plain detents, window edge, time wrap
        turn_detent(1'b1, 32'd1000);
        turn_detent(1'b1, 32'd1000 + PAUSE_US_RST);
        turn_detent(1'b0, 32'hffff_fff0);
        turn_detent(1'b0, 32'h0000_0010);
        // Unchanged pins, a skipped quarter and its return
        send_item(OP_SAMPLE, 2'b11, 32'd20, 16'sd0);
        send_item(OP_SAMPLE, 2'b00, 32'd30, 16'sd0);
        send_item(OP_SAMPLE, 2'b11, 32'd40, 16'sd0);
        turn_k = 2'd0;
        // Loads at the extremes, clamp, unused code, motion seen after a load
        send_item(OP_LOAD, 2'b00, 32'hffff_ffff, 16'sh7fff);
        send_item(OP_NONE, 2'b10, 32'h5a5a_a5a5, -16'sh8000);
        send_item(OP_CLAMP, 2'b01, 32'h0, 16'sh7fff);
        send_item(OP_SAMPLE, 2'b11, 32'd50, -16'sd1);
        send_item(OP_LOAD, 2'b11, 32'h0, -16'sh8000);
        send_item(OP_CLAMP, 2'b11, 32'h0, 16'sd0);
        send_item(OP_SAMPLE, 2'b11, 32'd60, 16'sd0);
        clock_us = 32'd60;

        // Random traffic under a series of settings, extremes first
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin pause = 32'd0; step = 8'd1; lo = -16'sh8000; hi = 16'sh7fff; end
                1: begin pause = 32'hffff_ffff; step = 8'd255; lo = -16'sd100; hi = 16'sd100; end
                2: begin pause = 32'hffff_ffff; step = 8'd0; lo = 16'sd500; hi = -16'sd500; end
                3: begin pause = 32'd2000; step = 8'd3; lo = 16'sd0; hi = 16'sd0; end
                4: begin pause = $urandom_range(0, 100000); step = STEP_W'($urandom);
                         lo = POS_W'($urandom); hi = POS_W'($urandom); end
                5: begin pause = $urandom; step = STEP_W'($urandom);
                         lo = POS_W'($urandom); hi = POS_W'($urandom); end
                6: begin pause = 32'd1; step = 8'd128; lo = -16'sh8000; hi = -16'sh8000; end
                default: begin pause = PAUSE_US_RST; step = FAST_STEP_RST; lo = POS_MIN_RST;
                               hi = POS_MAX_RST; end
            endcase
            // Calm stretch mid-run, and none at all in the last phase
            idle_on = (phase != 3) && (phase != PHASE_COUNT - 1);
            apply_settings(pause, step, lo, hi);
            run_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (4) @(posedge clk);

        $display("Checked %0d decoder results, %0d of them flagging motion.",
                 reports_checked, motion_reports);
        $display("Traffic: rotation runs, glitches, loads, clamps over %0d settings.",
                 PHASE_COUNT + 1);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qdec_pkg.sv
rtl/qdec_if.sv
rtl/qdec_regs.sv
rtl/qdec_core.sv
rtl/quadrature_decoder_accel_unit.sv
rtl/qdec_checker.sv
tb/quadrature_decoder_accel_unit_check.sv
tb/quadrature_decoder_accel_unit_test.sv
